[sv/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the profiled drive controller
// widths of the stream fields, config register map and profile constants
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int unsigned POS_W    = 24;
    localparam int unsigned HEAD_W   = 16;
    localparam int unsigned DT_W     = 8;
    localparam int unsigned PWR_W    = 7;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned FWD_W    = 8;
    localparam int unsigned ERR_W    = POS_W + 1;
    localparam int unsigned PROD_W   = ERR_W + GAIN_W + 1;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // stream beat layouts
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 32;

    localparam logic [TIME_W-1:0] SETTLE_MS       = TIME_W'(300);
    localparam logic [ERR_W-1:0]  TOLERANCE_TICKS = ERR_W'(10);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TARGET_POSITION = 3'd0,
        CFG_MAX_POWER       = 3'd1,
        CFG_ACCEL_GAIN      = 3'd2,
        CFG_DECEL_GAIN      = 3'd3,
        CFG_TIMEOUT_MS      = 3'd4,
        CFG_MIN_ACCEL_POWER = 3'd5,
        CFG_MIN_DRIVE_POWER = 3'd6
    } t_cfg_idx;

endpackage

[sv/profiled_drive_controller.sv]
// ----------------------------------------------------------------------------
// profiled_drive_controller: trapezoid profile p-controller with settle timeout
// one control tick in, one power/turn/done beat out, three register stages
// ----------------------------------------------------------------------------
// from input beat to output beat a tick passes the input, operand and result registers
// throughput: one tick per cycle unless m_axis_tready stalls the output; the timers and the finished flag are updated
//   in the first stage, so each tick sees the state left by the one before it
// the 25x17 product of the second stage sets the clock period
// reset (synchronous, active low): config back to defaults, timers cleared,
//   move finished until a restart tick arrives, pipeline emptied
module profiled_drive_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // tick stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] restart, [24:1] drive_position, [40:25] heading, [48:41] elapsed_ms,
    // [55:49] zero
    input  logic [pdc_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] forward_power, [23:8] turn_power, [24] done_res, [31:25] zero
    output logic [pdc_pkg::M_DATA_W-1:0]      m_axis_tdata
);
    import pdc_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [POS_W-1:0]  r_target;
    logic [PWR_W-1:0]         r_max_power;
    logic [GAIN_W-1:0]        r_accel_gain;
    logic [GAIN_W-1:0]        r_decel_gain;
    logic [TIME_W-1:0]        r_timeout;
    logic [PWR_W-1:0]         r_min_accel;
    logic [PWR_W-1:0]         r_min_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_max_power  <= '1;
            r_accel_gain <= '0;
            r_decel_gain <= '0;
            r_timeout    <= '1;
            r_min_accel  <= '0;
            r_min_drive  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TARGET_POSITION: r_target     <= i_cfg_wdata[POS_W-1:0];
                CFG_MAX_POWER:       r_max_power  <= i_cfg_wdata[PWR_W-1:0];
                CFG_ACCEL_GAIN:      r_accel_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DECEL_GAIN:      r_decel_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_TIMEOUT_MS:      r_timeout    <= i_cfg_wdata[TIME_W-1:0];
                CFG_MIN_ACCEL_POWER: r_min_accel  <= i_cfg_wdata[PWR_W-1:0];
                CFG_MIN_DRIVE_POWER: r_min_drive  <= i_cfg_wdata[PWR_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- elastic pipeline control ----------------
    logic r_s1_valid, r_s2_valid, r_o_valid;
    logic o_ready, s2_ready, s1_ready;
    logic s_fire, s1_fire, s2_fire;

    assign o_ready  = !r_o_valid || m_axis_tready;
    assign s2_ready = !r_s2_valid || o_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign s_axis_tready = s1_ready;
    assign s_fire  = s_axis_tvalid && s1_ready;
    assign s1_fire = r_s1_valid && s2_ready;
    assign s2_fire = r_s2_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= s_axis_tvalid;
            if (s2_ready) r_s2_valid <= r_s1_valid;
            if (o_ready)  r_o_valid  <= r_s2_valid;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic                     r_s1_restart;
    logic signed [POS_W-1:0]  r_s1_pos;
    logic signed [HEAD_W-1:0] r_s1_head;
    logic [DT_W-1:0]          r_s1_dt;

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_restart <= s_axis_tdata[0];
            r_s1_pos     <= s_axis_tdata[POS_W:1];
            r_s1_head    <= s_axis_tdata[POS_W+HEAD_W:POS_W+1];
            r_s1_dt      <= s_axis_tdata[POS_W+HEAD_W+DT_W:POS_W+HEAD_W+1];
        end
    end

    // ---------------- move state ----------------
    logic [TIME_W-1:0] r_settle_time, r_run_time;
    logic              r_finished;
    logic [TIME_W-1:0] n_settle_time, n_run_time;
    logic              n_finished;

    // stage 1 combinational work: timers, profile select, turn correction
    logic                      active;
    logic [TIME_W:0]           run_sum, settle_sum;
    logic [TIME_W-1:0]         run_upd, settle_upd;
    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          err_mag;
    logic [POS_W-1:0]          tgt_mag;
    logic                      accel_half;
    logic                      dir_pos;
    logic [PWR_W-1:0]          base_mag;
    logic signed [FWD_W-1:0]   n_base;
    logic signed [ERR_W-1:0]   n_operand;
    logic [GAIN_W-1:0]         n_gain;
    logic signed [HEAD_W-1:0]  n_turn;

    always_comb begin
        run_sum    = {1'b0, r_run_time} + (TIME_W+1)'(r_s1_dt);
        settle_sum = {1'b0, r_settle_time} + (TIME_W+1)'(r_s1_dt);
        run_upd    = run_sum[TIME_W] ? '1 : run_sum[TIME_W-1:0];
        settle_upd = settle_sum[TIME_W] ? '1 : settle_sum[TIME_W-1:0];

        // timers first: restart clears, a running tick accumulates
        if (r_s1_restart) begin
            n_run_time    = '0;
            n_settle_time = '0;
            active        = 1'b1;
        end else if (!r_finished) begin
            n_run_time    = run_upd;
            n_settle_time = settle_upd;
            active        = 1'b1;
        end else begin
            n_run_time    = r_run_time;
            n_settle_time = r_settle_time;
            active        = 1'b0;
        end

        err     = ERR_W'(r_target) - ERR_W'(r_s1_pos);
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : err;
        tgt_mag = r_target[POS_W-1] ? POS_W'(-r_target) : POS_W'(r_target);
        dir_pos = !r_target[POS_W-1] && (r_target != '0);

        // accelerate while more than half the distance remains
        accel_half = {err_mag, 1'b0} > (ERR_W+1)'(tgt_mag);
        if (accel_half) begin
            n_operand = ERR_W'(r_s1_pos);
            n_gain    = r_accel_gain;
            base_mag  = r_min_accel;
        end else begin
            n_operand = err;
            n_gain    = r_decel_gain;
            base_mag  = r_min_drive;
        end
        n_base = dir_pos ? FWD_W'(base_mag) : FWD_W'(-FWD_W'(base_mag));

        // negated heading, most negative heading saturates
        n_turn = (r_s1_head == {1'b1, {(HEAD_W-1){1'b0}}}) ?
                 {1'b0, {(HEAD_W-1){1'b1}}} : HEAD_W'(-r_s1_head);

        // settle and timeout checks close out the tick
        n_finished = r_finished;
        if (active) begin
            n_finished = 1'b0;
            if (err_mag < TOLERANCE_TICKS) begin
                if (n_settle_time > SETTLE_MS) n_finished = 1'b1;
            end else begin
                n_settle_time = '0;
            end
            if (n_run_time > r_timeout) n_finished = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_time <= '0;
            r_run_time    <= '0;
            r_finished    <= 1'b1;
        end else if (s1_fire) begin
            r_settle_time <= n_settle_time;
            r_run_time    <= n_run_time;
            r_finished    <= n_finished;
        end
    end

    // ---------------- stage 2: operand register, then product ----------------
    logic signed [ERR_W-1:0]  r_s2_operand;
    logic [GAIN_W-1:0]        r_s2_gain;
    logic signed [FWD_W-1:0]  r_s2_base;
    logic                     r_s2_active;
    logic signed [HEAD_W-1:0] r_s2_turn;
    logic                     r_s2_done;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_operand <= n_operand;
            r_s2_gain    <= n_gain;
            r_s2_base    <= n_base;
            r_s2_active  <= active;
            r_s2_turn    <= n_turn;
            r_s2_done    <= n_finished;
        end
    end

    // Q8 power: base * 256 plus operand times the Q8.8 gain
    logic signed [PROD_W-1:0] n_power;
    always_comb begin
        n_power = PROD_W'(r_s2_operand * $signed({1'b0, r_s2_gain}))
                + {{(PROD_W-FWD_W-8){r_s2_base[FWD_W-1]}}, r_s2_base, 8'h00};
    end

    // ---------------- stage 3: clamp and result register ----------------
    logic signed [PROD_W-1:0] r_s3_power;
    logic                     r_s3_active;
    logic signed [HEAD_W-1:0] r_s3_turn;
    logic                     r_s3_done;

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_s3_power  <= n_power;
            r_s3_active <= r_s2_active;
            r_s3_turn   <= r_s2_turn;
            r_s3_done   <= r_s2_done;
        end
    end

    assign m_axis_tvalid = r_o_valid;

    logic signed [PROD_W-1:0] lim;
    logic signed [PROD_W-1:0] clamped;
    logic signed [PROD_W-1:0] quot;
    logic signed [FWD_W-1:0]  fwd;

    always_comb begin
        lim = PROD_W'({r_max_power, 8'h00});
        if (r_s3_power > lim)       clamped = lim;
        else if (r_s3_power < -lim) clamped = -lim;
        else                        clamped = r_s3_power;
        // divide by 256 rounding toward zero
        quot = clamped >>> 8;
        if (clamped[PROD_W-1] && (clamped[7:0] != 8'h00)) quot = quot + PROD_W'(1);
        fwd = r_s3_active ? quot[FWD_W-1:0] : '0;
    end

    // result beat is held in the stage 3 registers until taken
    assign m_axis_tdata = {{(M_DATA_W-FWD_W-HEAD_W-1){1'b0}},
                           r_s3_done,
                           (r_s3_active ? r_s3_turn : {HEAD_W{1'b0}}),
                           fwd};

    // ---------------- assertions ----------------
    // once finished, the timers hold until a restart tick passes stage 1
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished && !(s1_fire && r_s1_restart) |=> $stable(r_run_time))
        else $error("run timer moved while finished");

    // run time only grows between restarts
    a_run_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_s1_restart |=> r_run_time >= $past(r_run_time))
        else $error("run timer went backwards");

    // settle timer is cleared more often than the run timer, never ahead of it
    a_settle_le_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle_time <= r_run_time)
        else $error("settle timer exceeds run timer");

endmodule
